### hdl/nfsa_pkg.sv
`timescale 1ns / 1ps

package nfsa_pkg;

  localparam int DESCRIPTORS_DEF = 256;
  localparam int ADDR_WIDTH_DEF  = 32;

  localparam logic [31:0] ALIGN_MASK = 32'hFFFF_FFF0;
  localparam logic [31:0] ALIGN_ADD  = 32'd15;

  localparam int CFG_INDEX_W = 2;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_NOFIT   = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_NOADDR  = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] CFG_POOL_START = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_POOL_SIZE  = 2'd1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] amount;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] block_address;
    logic [31:0] largest_free;
  } rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT,
    S_A_RD0,
    S_A_WT0,
    S_A_LOOP,
    S_A_NODE,
    S_A_FIN,
    S_A_GRAB_RD,
    S_A_GRAB_CK,
    S_A_WR1,
    S_A_WR2,
    S_A_WR3,
    S_R_LOOP,
    S_R_NODE,
    S_R_UNLINK,
    S_F_LOOP,
    S_F_NODE,
    S_F_MR,
    S_F_ML,
    S_F_WR2,
    S_DONE
  } state_t;

endpackage

### hdl/next_fit_segment_allocator_unit.sv
`timescale 1ns / 1ps

// next-fit segment allocator over a table of segment descriptors
// command channel: req is taken at a clock edge where start is high and busy is
//   low; opcode allocate, release or query largest free size
// result channel: rsp is shown for exactly one cycle with done high; the
//   receiver cannot stall, so nothing is held back
// configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
//   index 0 pool start, index 1 pool size; either write rebuilds the table as
//   one free segment; cfg_ready is high only while the block is idle and start is low
// sequencing: every command goes through a sequencer over the descriptor
//   memories (one read port each, registered read); allocate and query
//   visit the free list entries in turn, and on a split scan the descriptors
//   in turn for a spare one; release passes the allocated entries, then the
//   free entries, then the merge steps; the result is shown in the state
//   after the last step, then busy drops
// reset and configuration writes start a clearing pass, one descriptor
//   after another over the memories with busy high; no command is taken during it
module next_fit_segment_allocator_unit #(
  parameter int DESCRIPTORS = nfsa_pkg::DESCRIPTORS_DEF,
  parameter int ADDR_WIDTH  = nfsa_pkg::ADDR_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  nfsa_pkg::req_t                   req,
  output logic                             done,
  output nfsa_pkg::rsp_t                   rsp,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nfsa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                      cfg_data
);

  localparam int AW = (DESCRIPTORS > 1) ? $clog2(DESCRIPTORS) : 1;
  localparam int IW = $clog2(DESCRIPTORS + 2);
  localparam int SW = ADDR_WIDTH;
  localparam logic [IW-1:0] NIL   = IW'(DESCRIPTORS);
  localparam logic [IW-1:0] HEADQ = IW'(DESCRIPTORS + 1);
  localparam logic [AW-1:0] LAST  = AW'(DESCRIPTORS - 1);

  // descriptor memories
  logic [SW-1:0] start_mem [DESCRIPTORS];
  logic [31:0]   len_mem   [DESCRIPTORS];
  logic [IW-1:0] next_mem  [DESCRIPTORS];
  logic          used_mem  [DESCRIPTORS];

  logic [AW-1:0] rd_idx;
  logic [SW-1:0] start_rd;
  logic [31:0]   len_rd;
  logic [IW-1:0] next_rd;
  logic          used_rd;

  logic          st_we, ln_we, nx_we, us_we;
  logic [AW-1:0] st_wa, ln_wa, nx_wa, us_wa;
  logic [SW-1:0] st_wd;
  logic [31:0]   ln_wd;
  logic [IW-1:0] nx_wd;
  logic          us_wd;

  nfsa_pkg::state_t state, state_next;

  logic [31:0]   pool_start, pool_size;
  logic [AW-1:0] cnt, scan;
  logic [IW-1:0] free_head, alloc_head, search_start;
  logic [IW-1:0] q, p, prev, m, r, n_p, n_m, nm;
  logic [SW-1:0] s_p, s_m, s_q;
  logic [31:0]   l_p, l_m, l_q, lm, maxval;
  logic [32:0]   need;
  logic          query, split, merge_r, merge_l;
  nfsa_pkg::rsp_t res;
  logic [31:0]   req_addr_l;

  logic          accept, cfg_write, cfg_hit;
  logic          p_nil, eff_nil, ss_nil, fits, exact, mr, ml;
  logic [IW-1:0] eff_p, eff_q, link, ss0;
  logic [32:0]   need_c;
  logic [SW-1:0] sum_m, sum_q;

  assign accept    = start && (state == nfsa_pkg::S_IDLE);
  assign cfg_ready = (state == nfsa_pkg::S_IDLE) && !start;
  assign cfg_write = cfg_valid && cfg_ready;
  assign cfg_hit   = (cfg_index == nfsa_pkg::CFG_POOL_START) ||
                     (cfg_index == nfsa_pkg::CFG_POOL_SIZE);

  assign p_nil   = p >= NIL;
  assign ss_nil  = search_start >= NIL;
  assign eff_p   = p_nil ? free_head : p;
  assign eff_q   = p_nil ? HEADQ : q;
  assign eff_nil = eff_p >= NIL;
  assign need_c  = ({1'b0, req.amount} + {1'b0, nfsa_pkg::ALIGN_ADD}) &
                   {1'b1, nfsa_pkg::ALIGN_MASK};
  assign fits    = !query && ({1'b0, len_rd} >= need);
  assign exact   = {1'b0, len_rd} == need;
  assign link    = split ? r : n_p;
  assign sum_m   = s_m + SW'(l_m);
  assign sum_q   = s_q + SW'(l_q);
  assign mr      = !p_nil && (sum_m == s_p);
  assign ml      = (q != NIL) && (sum_q == s_m);
  assign ss0     = ss_nil ? m : search_start;

  assign busy = state != nfsa_pkg::S_IDLE;
  assign done = state == nfsa_pkg::S_DONE;
  assign rsp  = res;

  // memories
  always_ff @(posedge clk) begin
    if (st_we) start_mem[st_wa] <= st_wd;
    if (ln_we) len_mem[ln_wa] <= ln_wd;
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    if (us_we) used_mem[us_wa] <= us_wd;
    start_rd <= start_mem[rd_idx];
    len_rd   <= len_mem[rd_idx];
    next_rd  <= next_mem[rd_idx];
    used_rd  <= used_mem[scan];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      nfsa_pkg::S_IDLE: begin
        if (accept) begin
          case (req.opcode)
            nfsa_pkg::OP_ALLOC: begin
              if (req.amount == 32'd0 || ss_nil) state_next = nfsa_pkg::S_DONE;
              else state_next = nfsa_pkg::S_A_RD0;
            end
            nfsa_pkg::OP_QUERY: begin
              if (ss_nil) state_next = nfsa_pkg::S_DONE;
              else state_next = nfsa_pkg::S_A_RD0;
            end
            nfsa_pkg::OP_RELEASE: state_next = nfsa_pkg::S_R_LOOP;
            default: state_next = nfsa_pkg::S_DONE;
          endcase
        end else if (cfg_write && cfg_hit) begin
          state_next = nfsa_pkg::S_INIT;
        end
      end
      nfsa_pkg::S_INIT: begin
        if (cnt == LAST) state_next = nfsa_pkg::S_IDLE;
      end
      nfsa_pkg::S_A_RD0: state_next = nfsa_pkg::S_A_WT0;
      nfsa_pkg::S_A_WT0: state_next = nfsa_pkg::S_A_LOOP;
      nfsa_pkg::S_A_LOOP: begin
        if (eff_nil) state_next = nfsa_pkg::S_A_FIN;
        else state_next = nfsa_pkg::S_A_NODE;
      end
      nfsa_pkg::S_A_NODE: begin
        if (fits) begin
          if (exact) state_next = nfsa_pkg::S_A_WR2;
          else state_next = nfsa_pkg::S_A_GRAB_RD;
        end else if (p == search_start) begin
          state_next = nfsa_pkg::S_A_FIN;
        end else begin
          state_next = nfsa_pkg::S_A_LOOP;
        end
      end
      nfsa_pkg::S_A_FIN:     state_next = nfsa_pkg::S_DONE;
      nfsa_pkg::S_A_GRAB_RD: state_next = nfsa_pkg::S_A_GRAB_CK;
      nfsa_pkg::S_A_GRAB_CK: begin
        if (!used_rd) state_next = nfsa_pkg::S_A_WR1;
        else if (scan == LAST) state_next = nfsa_pkg::S_DONE;
        else state_next = nfsa_pkg::S_A_GRAB_RD;
      end
      nfsa_pkg::S_A_WR1: state_next = nfsa_pkg::S_A_WR2;
      nfsa_pkg::S_A_WR2: state_next = nfsa_pkg::S_A_WR3;
      nfsa_pkg::S_A_WR3: state_next = nfsa_pkg::S_DONE;
      nfsa_pkg::S_R_LOOP: begin
        if (p_nil) state_next = nfsa_pkg::S_DONE;
        else state_next = nfsa_pkg::S_R_NODE;
      end
      nfsa_pkg::S_R_NODE: begin
        if (start_rd == SW'(req_addr_l)) state_next = nfsa_pkg::S_R_UNLINK;
        else state_next = nfsa_pkg::S_R_LOOP;
      end
      nfsa_pkg::S_R_UNLINK: state_next = nfsa_pkg::S_F_LOOP;
      nfsa_pkg::S_F_LOOP: begin
        if (p_nil) state_next = nfsa_pkg::S_F_MR;
        else state_next = nfsa_pkg::S_F_NODE;
      end
      nfsa_pkg::S_F_NODE: begin
        if (s_m <= start_rd) state_next = nfsa_pkg::S_F_MR;
        else state_next = nfsa_pkg::S_F_LOOP;
      end
      nfsa_pkg::S_F_MR:  state_next = nfsa_pkg::S_F_ML;
      nfsa_pkg::S_F_ML:  state_next = nfsa_pkg::S_F_WR2;
      nfsa_pkg::S_F_WR2: state_next = nfsa_pkg::S_DONE;
      nfsa_pkg::S_DONE:  state_next = nfsa_pkg::S_IDLE;
      default:           state_next = nfsa_pkg::S_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    rd_idx = p[AW-1:0];
    st_we = 1'b0; st_wa = m[AW-1:0]; st_wd = '0;
    ln_we = 1'b0; ln_wa = m[AW-1:0]; ln_wd = '0;
    nx_we = 1'b0; nx_wa = m[AW-1:0]; nx_wd = NIL;
    us_we = 1'b0; us_wa = m[AW-1:0]; us_wd = 1'b0;
    case (state)
      nfsa_pkg::S_INIT: begin
        st_we = 1'b1; st_wa = cnt;
        st_wd = (cnt == '0) ? SW'(pool_start) : '0;
        ln_we = 1'b1; ln_wa = cnt;
        ln_wd = (cnt == '0) ? pool_size : '0;
        nx_we = 1'b1; nx_wa = cnt; nx_wd = NIL;
        us_we = 1'b1; us_wa = cnt; us_wd = (cnt == '0);
      end
      nfsa_pkg::S_A_RD0:  rd_idx = search_start[AW-1:0];
      nfsa_pkg::S_A_LOOP: rd_idx = eff_p[AW-1:0];
      nfsa_pkg::S_A_WR1: begin
        us_we = 1'b1; us_wa = r[AW-1:0]; us_wd = 1'b1;
        st_we = 1'b1; st_wa = r[AW-1:0]; st_wd = s_p + SW'(need[31:0]);
        ln_we = 1'b1; ln_wa = r[AW-1:0]; ln_wd = l_p - need[31:0];
        nx_we = 1'b1; nx_wa = r[AW-1:0]; nx_wd = n_p;
      end
      nfsa_pkg::S_A_WR2: begin
        ln_we = 1'b1; ln_wa = p[AW-1:0]; ln_wd = need[31:0];
        nx_we = 1'b1; nx_wa = p[AW-1:0]; nx_wd = alloc_head;
      end
      nfsa_pkg::S_A_WR3: begin
        nx_we = q != HEADQ; nx_wa = q[AW-1:0]; nx_wd = link;
      end
      nfsa_pkg::S_R_UNLINK: begin
        nx_we = prev != NIL; nx_wa = prev[AW-1:0]; nx_wd = n_m;
      end
      nfsa_pkg::S_F_ML: begin
        nx_we = 1'b1; nx_wa = m[AW-1:0]; nx_wd = nm;
        ln_we = 1'b1; ln_wa = m[AW-1:0]; ln_wd = lm;
        us_we = merge_r; us_wa = p[AW-1:0]; us_wd = 1'b0;
      end
      nfsa_pkg::S_F_WR2: begin
        nx_we = q != NIL; nx_wa = q[AW-1:0]; nx_wd = merge_l ? nm : m;
        ln_we = (q != NIL) && merge_l; ln_wa = q[AW-1:0]; ln_wd = l_q + lm;
        us_we = (q != NIL) && merge_l; us_wa = m[AW-1:0]; us_wd = 1'b0;
      end
      default: rd_idx = p[AW-1:0];
    endcase
  end

  // the command address is held by the register below for the whole transaction
  always_ff @(posedge clk) begin
    if (accept) req_addr_l <= req.address;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= nfsa_pkg::S_INIT;
      cnt          <= '0;
      pool_start   <= '0;
      pool_size    <= '0;
      free_head    <= '0;
      alloc_head   <= NIL;
      search_start <= '0;
    end else begin
      state <= state_next;
      case (state)
        nfsa_pkg::S_IDLE: begin
          if (accept) begin
            need    <= need_c;
            query   <= req.opcode == nfsa_pkg::OP_QUERY;
            maxval  <= '0;
            p       <= alloc_head;
            prev    <= NIL;
            if (req.opcode == nfsa_pkg::OP_ALLOC && req.amount == 32'd0) begin
              res <= '{nfsa_pkg::ST_ZERO, 32'd0, 32'd0};
            end else if (req.opcode == nfsa_pkg::OP_ALLOC && ss_nil) begin
              res <= '{nfsa_pkg::ST_NOFIT, 32'd0, 32'd0};
            end else begin
              res <= '0;
            end
          end else if (cfg_write) begin
            cnt <= '0;
            if (cfg_index == nfsa_pkg::CFG_POOL_START) pool_start <= cfg_data;
            if (cfg_index == nfsa_pkg::CFG_POOL_SIZE) pool_size <= cfg_data;
          end
        end
        nfsa_pkg::S_INIT: begin
          cnt <= cnt + AW'(1);
          if (cnt == LAST) begin
            free_head    <= '0;
            alloc_head   <= NIL;
            search_start <= '0;
          end
        end
        nfsa_pkg::S_A_WT0: begin
          q <= search_start;
          p <= next_rd;
        end
        nfsa_pkg::S_A_LOOP: begin
          q <= eff_q;
          p <= eff_p;
        end
        nfsa_pkg::S_A_NODE: begin
          if (fits) begin
            s_p   <= start_rd;
            l_p   <= len_rd;
            n_p   <= next_rd;
            split <= !exact;
            scan  <= '0;
          end else begin
            if (len_rd > maxval) maxval <= len_rd;
            q <= p;
            p <= next_rd;
          end
        end
        nfsa_pkg::S_A_FIN: begin
          if (query) begin
            res.largest_free <= (maxval < nfsa_pkg::ALIGN_ADD) ? 32'd0 :
                                ((maxval - nfsa_pkg::ALIGN_ADD) & nfsa_pkg::ALIGN_MASK);
          end else begin
            res.status <= nfsa_pkg::ST_NOFIT;
          end
        end
        nfsa_pkg::S_A_GRAB_CK: begin
          if (!used_rd) r <= IW'(scan);
          else if (scan == LAST) res.status <= nfsa_pkg::ST_FULL;
          else scan <= scan + AW'(1);
        end
        nfsa_pkg::S_A_WR2: alloc_head <= p;
        nfsa_pkg::S_A_WR3: begin
          if (q == HEADQ) begin
            free_head    <= link;
            search_start <= link;
          end else begin
            search_start <= q;
          end
          res.block_address <= 32'(s_p);
        end
        nfsa_pkg::S_R_LOOP: begin
          if (p_nil) res.status <= nfsa_pkg::ST_NOADDR;
        end
        nfsa_pkg::S_R_NODE: begin
          if (start_rd == SW'(req_addr_l)) begin
            m   <= p;
            s_m <= start_rd;
            l_m <= len_rd;
            n_m <= next_rd;
          end else begin
            prev <= p;
            p    <= next_rd;
          end
        end
        nfsa_pkg::S_R_UNLINK: begin
          if (prev == NIL) alloc_head <= n_m;
          p <= free_head;
          q <= NIL;
        end
        nfsa_pkg::S_F_LOOP: begin
          if (p_nil) p <= NIL;
        end
        nfsa_pkg::S_F_NODE: begin
          if (s_m <= start_rd) begin
            s_p <= start_rd;
            l_p <= len_rd;
            n_p <= next_rd;
          end else begin
            q   <= p;
            s_q <= start_rd;
            l_q <= len_rd;
            p   <= next_rd;
          end
        end
        nfsa_pkg::S_F_MR: begin
          merge_r      <= mr;
          lm           <= mr ? (l_m + l_p) : l_m;
          nm           <= mr ? n_p : p;
          search_start <= (mr && (p == ss0)) ? m : ss0;
        end
        nfsa_pkg::S_F_ML: begin
          merge_l <= ml;
          if (ml && (m == search_start)) search_start <= q;
        end
        nfsa_pkg::S_F_WR2: begin
          if (q == NIL) free_head <= m;
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transaction accepted without going busy");
  a_heads_valid: assert property (@(posedge clk) disable iff (rst)
    (free_head <= NIL) && (alloc_head <= NIL) && (search_start <= NIL))
    else $error("list head out of range");
  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.status != nfsa_pkg::ST_OK)) |-> (rsp.block_address == 32'd0))
    else $error("failed transaction reports an address");
`endif

endmodule
